[hw/rtl/tty_line_input_buffer_defines.svh]
// Assertion macros for the RTL of the line input buffer (included by the back end).
// Each macro expects clk and arst_n in scope.
`ifndef TTY_LINE_INPUT_BUFFER_DEFINES_SVH
`define TTY_LINE_INPUT_BUFFER_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define TLIB_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a same-cycle implication.
`define TLIB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another one in the next cycle.
`define TLIB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tlib_pkg.sv]
`timescale 1ns / 1ps

package tlib_pkg;

	// Default ring size and the most characters one read transaction returns
	localparam int BUFFER_DEPTH_DEFAULT = 64;
	localparam int MAX_RESULTS          = 64;

	// Entries in the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Character codes
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_DEL = 8'd127;

	// Input operation codes
	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] char_in;
		logic [7:0] read_size;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       last;
		logic       accepted;
		logic       data_left;
		logic [6:0] fill_level;
	} out_item_t;

	// Classified command kinds
	typedef enum logic [1:0] {
		CMD_STORE = 2'd0,
		CMD_ERASE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_kind_t;

	// Command: data is the character for a store, the size for a read
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_link_t;

endpackage

[hw/rtl/tty_line_input_buffer.sv]
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// item      start / busy              item   (operation, char_in, read_size)
// config    cfg_valid / cfg_ready     cfg_data (canonical_mode)
// result    strobe, one cycle         result (out_char ... fill_level)
//
// A transaction is taken whenever the two-entry command queue has room.
// A feed is executed by the back end from its idle state; a read first fetches from the
// character RAM (registered read port) and then delivers one character per cycle.
// Reset clears pointers, count and queue; canonical mode resets to 1; no clearing pass.
// The receiver cannot stall: each result shows for one cycle behind strobe.

module tty_line_input_buffer #(
	parameter int BUFFER_DEPTH = tlib_pkg::BUFFER_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tlib_pkg::in_item_t  item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	output logic                strobe,
	output tlib_pkg::out_item_t result
);

	tlib_pkg::cmd_link_t link;
	logic                pop;
	logic                canonical_q;

	assign cfg_ready = 1'b1;

	// Hold the canonical mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canonical_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			canonical_q <= cfg_data;
		end
	end

	tlib_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.pop   (pop),
		.link  (link)
	);

	tlib_back #(
		.DEPTH(BUFFER_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.canonical(canonical_q),
		.link     (link),
		.pop      (pop),
		.strobe   (strobe),
		.result   (result)
	);

endmodule

[hw/rtl/tlib_ram.sv]
`timescale 1ns / 1ps

module tlib_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tlib_pkg::BUFFER_DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/tlib_front.sv]
`timescale 1ns / 1ps

module tlib_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tlib_pkg::in_item_t  item,
	input  logic                pop,
	output tlib_pkg::cmd_link_t link
);

	localparam int QD  = tlib_pkg::QUEUE_DEPTH;
	localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCW = $clog2(QD + 1);

	tlib_pkg::cmd_t   cmd_new;
	tlib_pkg::cmd_t   queue_q [QD];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QCW-1:0]   cnt_q;
	logic             push;
	logic             take;

	// Classify the incoming transaction
	always_comb begin
		cmd_new.kind = tlib_pkg::CMD_STORE;
		cmd_new.data = item.char_in;
		if (item.operation == tlib_pkg::OP_READ) begin
			cmd_new.kind = tlib_pkg::CMD_READ;
			cmd_new.data = item.read_size;
		end else if (item.char_in == tlib_pkg::CH_CR) begin
			cmd_new.data = tlib_pkg::CH_LF;
		end else if (item.char_in == tlib_pkg::CH_BS || item.char_in == tlib_pkg::CH_DEL) begin
			cmd_new.kind = tlib_pkg::CMD_ERASE;
		end
	end

	assign busy = (cnt_q == QCW'(QD));
	assign push = start && !busy;
	assign take = pop && (cnt_q != '0);

	assign link.valid = (cnt_q != '0);
	assign link.cmd   = queue_q[rd_q];

	// Store commands in arrival order
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_q] <= cmd_new;
		end
	end

	// Advance queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QAW'(QD - 1)) ? '0 : wr_q + 1'b1;
			end
			if (take) begin
				rd_q <= (rd_q == QAW'(QD - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/tlib_back.sv]
`timescale 1ns / 1ps
`include "tty_line_input_buffer_defines.svh"

module tlib_back #(
	parameter int DEPTH = tlib_pkg::BUFFER_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                canonical,
	input  tlib_pkg::cmd_link_t link,
	output logic                pop,
	output logic                strobe,
	output tlib_pkg::out_item_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = $clog2(tlib_pkg::MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_READ = 2'b10
	} bk_state_t;

	bk_state_t           state_q, state_d;
	logic [AW-1:0]       wp_q, wp_d;
	logic [AW-1:0]       rp_q, rp_d;
	logic [CW-1:0]       count_q, count_d;
	logic [RW-1:0]       rem_q, rem_d;
	logic                we;
	logic [AW-1:0]       raddr;
	logic [7:0]          rdata;
	logic                stop;
	logic                strobe_d;
	tlib_pkg::out_item_t res_d;
	logic                strobe_q;
	tlib_pkg::out_item_t res_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
	endfunction

	tlib_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(wp_q),
		.wdata(link.cmd.data),
		.raddr(raddr),
		.rdata(rdata)
	);

	// End a read on newline in canonical mode, on size, or when the ring drains
	assign stop = (canonical && rdata == tlib_pkg::CH_LF) || (rem_q == RW'(1)) ||
		(count_q == CW'(1));

	// Execute one command, or deliver one character of a read
	always_comb begin
		state_d  = state_q;
		wp_d     = wp_q;
		rp_d     = rp_q;
		count_d  = count_q;
		rem_d    = rem_q;
		pop      = 1'b0;
		we       = 1'b0;
		raddr    = rp_q;
		strobe_d = 1'b0;
		res_d    = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (link.valid) begin
					pop        = 1'b1;
					strobe_d   = 1'b1;
					res_d.last = 1'b1;
					case (link.cmd.kind)
						tlib_pkg::CMD_STORE: begin
							if (count_q < CW'(DEPTH)) begin
								we             = 1'b1;
								wp_d           = ptr_inc(wp_q);
								count_d        = count_q + 1'b1;
								res_d.accepted = 1'b1;
							end
						end
						tlib_pkg::CMD_ERASE: begin
							if (count_q != '0) begin
								wp_d           = ptr_dec(wp_q);
								count_d        = count_q - 1'b1;
								res_d.accepted = 1'b1;
							end
						end
						tlib_pkg::CMD_READ: begin
							if (link.cmd.data != '0 && count_q != '0) begin
								strobe_d   = 1'b0;
								res_d.last = 1'b0;
								state_d    = BK_READ;
								rem_d      = (link.cmd.data > 8'(tlib_pkg::MAX_RESULTS)) ?
									RW'(tlib_pkg::MAX_RESULTS) : RW'(link.cmd.data);
							end
						end
						default: begin
						end
					endcase
				end
			end
			BK_READ: begin
				rp_d             = ptr_inc(rp_q);
				raddr            = ptr_inc(rp_q);
				count_d          = count_q - 1'b1;
				rem_d            = rem_q - 1'b1;
				strobe_d         = 1'b1;
				res_d.out_char   = rdata;
				res_d.char_valid = 1'b1;
				res_d.last       = stop;
				if (stop) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
		res_d.data_left  = (count_d != '0);
		res_d.fill_level = 7'(count_d);
	end

	// Hold the result for its one cycle
	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	// Advance ring state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			wp_q     <= '0;
			rp_q     <= '0;
			count_q  <= '0;
			rem_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			wp_q     <= wp_d;
			rp_q     <= rp_d;
			count_q  <= count_d;
			rem_q    <= rem_d;
			strobe_q <= strobe_d;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

	`TLIB_ASSERT_NOW(a_count_bound, count_q <= CW'(DEPTH), "unread count above ring depth")
	`TLIB_ASSERT_IMP(a_empty_ptrs, count_q == '0, rp_q == wp_q, "empty ring with split pointers")
	`TLIB_ASSERT_NXT(a_read_emits, state_q == BK_READ, strobe_q && res_q.char_valid,
		"read cycle produced no character")
	`TLIB_ASSERT_IMP(a_read_not_acc, strobe_q && res_q.char_valid, !res_q.accepted,
		"read result marked accepted")

endmodule
